// ===== hdl/ptms_pkg.sv =====
// shared types, codes and defaults of the passcode table match store
`default_nettype none

package ptms_pkg;

  // defaults for the top level parameters
  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned CodeBytesDef  = 6;

  // field widths of the stream payloads
  localparam int unsigned ActionW    = 2;
  localparam int unsigned PasscodeW  = 48;
  localparam int unsigned SlotIndexW = 4;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned OutDataW   = 8;

  // request kinds
  typedef enum logic [ActionW-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  // result codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ZERO      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;   // latch request, restart the scan
    logic scan;    // issue table reads
    logic commit;  // write result, update the table
  } ptms_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // last slot compared this cycle
    logic out_free;   // result register can take a result
  } ptms_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ptms_dp.sv =====
// datapath: code table, scan compare, request and result registers
`default_nettype none

module ptms_dp #(
  parameter int unsigned TABLE_SLOTS = ptms_pkg::TableSlotsDef,
  parameter int unsigned CODE_BYTES  = ptms_pkg::CodeBytesDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ptms_pkg::ptms_cmd_t               cmd_i,
  output      ptms_pkg::ptms_sts_t               sts_o,
  input  wire logic [ptms_pkg::ActionW-1:0]      action_i,
  input  wire logic [ptms_pkg::PasscodeW-1:0]    passcode_i,
  input  wire logic [ptms_pkg::SlotIndexW-1:0]   slot_index_i,
  input  wire logic                              out_ready_i,
  output      logic                              out_valid_o,
  output      logic [ptms_pkg::StatusW-1:0]      status_o,
  output      logic [ptms_pkg::SlotW-1:0]        slot_o
);

  localparam int unsigned CodeW = CODE_BYTES * 8;
  localparam int unsigned AddrW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);

  // table storage and per-slot occupancy
  logic [CodeW-1:0]       mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;

  // request registers
  logic [ptms_pkg::ActionW-1:0]    action_q;
  logic [CodeW-1:0]                code_q;
  logic [ptms_pkg::SlotIndexW-1:0] index_q;

  // scan state
  logic [CntW-1:0]  addr_q, addr_d;
  logic             rd_pend_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [CodeW-1:0] rd_data_q;
  logic             issue;
  logic             hit_q, hit_d;
  logic [AddrW-1:0] hit_idx_q, hit_idx_d;
  logic             empty_q, empty_d;
  logic [AddrW-1:0] empty_idx_q, empty_idx_d;

  // result register
  logic                         out_valid_q;
  logic [ptms_pkg::StatusW-1:0] status_q;
  logic [ptms_pkg::SlotW-1:0]   slot_q;

  // result decode
  ptms_pkg::status_e          res_status;
  logic [ptms_pkg::SlotW-1:0] res_slot;
  logic                       wr_en;
  logic                       clr_en;
  logic [AddrW-1:0]           clr_idx;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      action_q <= action_i;
      code_q   <= CodeW'(passcode_i);
      index_q  <= slot_index_i;
    end
  end

  // read one slot per cycle until every slot is issued
  assign issue  = cmd_i.scan && (addr_q != CntW'(TABLE_SLOTS));
  assign addr_d = cmd_i.start ? '0 : (issue ? addr_q + CntW'(1) : addr_q);

  // first match and first empty slot over the scan
  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    if (cmd_i.start) begin
      hit_d   = 1'b0;
      empty_d = 1'b0;
    end else if (rd_pend_q) begin
      if (valid_q[rd_idx_q] && (rd_data_q == code_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = rd_idx_q;
      end
      if (!valid_q[rd_idx_q] && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = rd_idx_q;
      end
    end
  end

  // outcome of the request
  always_comb begin
    res_status = ptms_pkg::ST_NOT_FOUND;
    res_slot   = '0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    clr_idx    = AddrW'(index_q);
    case (action_q)
      ptms_pkg::ACT_LOOKUP: begin
        if (hit_q) begin
          res_status = ptms_pkg::ST_OK;
          res_slot   = ptms_pkg::SlotW'(hit_idx_q);
        end
      end
      ptms_pkg::ACT_ADD: begin
        if (code_q == '0) begin
          res_status = ptms_pkg::ST_ZERO;
        end else if (hit_q) begin
          res_status = ptms_pkg::ST_DUPLICATE;
        end else if (!empty_q) begin
          res_status = ptms_pkg::ST_FULL;
        end else begin
          res_status = ptms_pkg::ST_OK;
          res_slot   = ptms_pkg::SlotW'(empty_idx_q);
          wr_en      = cmd_i.commit;
        end
      end
      ptms_pkg::ACT_DELETE: begin
        if (32'(index_q) < TABLE_SLOTS) begin
          res_status = ptms_pkg::ST_OK;
          clr_en     = cmd_i.commit;
        end else begin
          res_status = ptms_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        res_status = ptms_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // occupancy update
  always_comb begin
    valid_d = valid_q;
    if (wr_en) valid_d[empty_idx_q] = 1'b1;
    if (clr_en) valid_d[clr_idx] = 1'b0;
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[empty_idx_q] <= code_q;
    if (issue) rd_data_q <= mem[addr_q[AddrW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      empty_q     <= 1'b0;
      empty_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      addr_q      <= addr_d;
      rd_pend_q   <= issue;
      rd_idx_q    <= addr_q[AddrW-1:0];
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      empty_q     <= empty_d;
      empty_idx_q <= empty_idx_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= res_status;
      slot_q   <= res_slot;
    end
  end

  assign sts_o.scan_last = rd_pend_q && (rd_idx_q == AddrW'(TABLE_SLOTS - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;

  // a result never overwrites one still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // an add only writes a slot that is empty
  a_add_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !valid_q[empty_idx_q])
    else $error("add wrote an occupied slot");

  // a found lookup points at an occupied slot
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && hit_q && (action_q == ptms_pkg::ACT_LOOKUP)) |-> valid_q[hit_idx_q])
    else $error("lookup hit on an empty slot");

  // the table is not read outside a scan
  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !$past(cmd_i.commit))
    else $error("table read outside a scan");

endmodule

`default_nettype wire

// ===== hdl/ptms_ctrl.sv =====
// controller: sequences accept, scan and result commit
`default_nettype none

module ptms_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire ptms_pkg::ptms_sts_t sts_i,
  output      ptms_pkg::ptms_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/passcode_table_match_store.sv =====
// top level of the passcode table match store
// Usage: one request enters on the s_axis channel and gives exactly one
// result on the m_axis channel. A request is a lookup (report the lowest
// slot holding the passcode), an add (write a new nonzero passcode into
// the lowest empty slot) or a delete (empty the slot named by index).
// Timing: after a request is taken the controller scans every slot
// through one registered memory read port and one comparator, one slot a
// cycle; the result is registered in the finish step after the scan,
// and a new request is taken once the controller is back in idle. The
// scan over the single read port sets the time one request takes.
// Stall: the result sits in an output register while m_axis_tready is
// low; the next request is taken and scanned meanwhile and waits at its
// commit step until the register frees.
// Reset: rst_ni clears the per-slot occupancy bits at once, so every slot
// reads as empty; no clearing pass is needed.
`default_nettype none

module passcode_table_match_store #(
  parameter int unsigned TABLE_SLOTS = ptms_pkg::TableSlotsDef,
  parameter int unsigned CODE_BYTES  = ptms_pkg::CodeBytesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // action [1:0], passcode [49:2], slot_index [53:50], zero [55:54]
  input  wire logic [ptms_pkg::InDataW-1:0]    s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status [2:0], slot [6:3], zero [7]
  output      logic [ptms_pkg::OutDataW-1:0]   m_axis_tdata
);

  ptms_pkg::ptms_cmd_t          cmd;
  ptms_pkg::ptms_sts_t          sts;
  logic [ptms_pkg::StatusW-1:0] status;
  logic [ptms_pkg::SlotW-1:0]   slot;

  // request sequencing
  ptms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and result datapath
  ptms_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .CODE_BYTES  (CODE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (s_axis_tdata[1:0]),
    .passcode_i   (s_axis_tdata[49:2]),
    .slot_index_i (s_axis_tdata[53:50]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_o     (status),
    .slot_o       (slot)
  );

  // result packing
  assign m_axis_tdata = {1'b0, slot, status};

endmodule

`default_nettype wire

// ===== bench/ptms_scoreboard_pkg.sv =====
// scoreboard for the passcode table match store: table predictor and result checker
`timescale 1ns / 1ps

package ptms_scoreboard_pkg;
  import ptms_pkg::*;

  localparam int unsigned CodeBitsTb = ptms_pkg::CodeBytesDef * 8;

  // one expected reply
  typedef struct {
    status_e    status;
    logic [3:0] slot;
  } reply_t;

  class passcode_scoreboard;
    logic [PasscodeW-1:0] codes [ptms_pkg::TableSlotsDef];
    reply_t               replies [$];
    int unsigned          errors;
    int unsigned          requests;
    int unsigned          status_hits [8];

    function new();
      foreach (codes[i]) codes[i] = '0;
      errors   = 0;
      requests = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // run one accepted request against the shadow table and queue its reply
    function void note_request(logic [ActionW-1:0] action, logic [PasscodeW-1:0] passcode,
                               logic [SlotIndexW-1:0] slot_index);
      logic [PasscodeW-1:0] code;
      reply_t               rep;
      int                   hit;
      int                   empty;
      code  = passcode & {{(PasscodeW - CodeBitsTb){1'b0}}, {CodeBitsTb{1'b1}}};
      rep.status = ST_NOT_FOUND;
      rep.slot   = '0;
      hit   = -1;
      empty = -1;
      // lowest matching and lowest empty slot
      for (int i = ptms_pkg::TableSlotsDef - 1; i >= 0; i--) begin
        if (code != '0 && codes[i] == code) hit = i;
        if (codes[i] == '0) empty = i;
      end
      case (action)
        ACT_LOOKUP: begin
          if (hit >= 0) begin
            rep.status = ST_OK;
            rep.slot   = 4'(hit);
          end
        end
        ACT_ADD: begin
          if (code == '0) rep.status = ST_ZERO;
          else if (hit >= 0) rep.status = ST_DUPLICATE;
          else if (empty < 0) rep.status = ST_FULL;
          else begin
            codes[empty] = code;
            rep.status   = ST_OK;
            rep.slot     = 4'(empty);
          end
        end
        ACT_DELETE: begin
          if (32'(slot_index) < ptms_pkg::TableSlotsDef) begin
            codes[slot_index] = '0;
            rep.status        = ST_OK;
          end else begin
            rep.status = ST_BAD_INDEX;
          end
        end
        default: rep.status = ST_NOT_FOUND;
      endcase
      replies.push_back(rep);
      requests++;
      status_hits[rep.status]++;
    endfunction

    // compare one accepted result with the oldest pending reply
    function void check_result(logic [StatusW-1:0] status, logic [SlotW-1:0] slot);
      reply_t rep;
      if (replies.size() == 0) begin
        $error("result with no request pending: status %0d slot %0d", status, slot);
        errors++;
        return;
      end
      rep = replies.pop_front();
      if (status !== rep.status) begin
        $error("status mismatch: expected %0d actual %0d", rep.status, status);
        errors++;
      end
      if (slot !== rep.slot) begin
        $error("slot mismatch: expected %0d actual %0d", rep.slot, slot);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// testbench top of the passcode table match store
`timescale 1ns / 1ps

module tb;
  import ptms_pkg::*;
  import ptms_scoreboard_pkg::*;

  localparam logic [ActionW-1:0] ActUnused     = 2'd3;
  localparam int unsigned        RandomReqs    = 830;
  localparam int unsigned        PoolSize      = 20;
  localparam int unsigned        WatchdogLimit = 2000;
  localparam int unsigned        DrainCycles   = 30;
  localparam logic [PasscodeW-1:0] CodeMax     = 48'hFFFF_FFFF_FFFF;
  localparam logic [PasscodeW-1:0] CodeMsb     = 48'h8000_0000_0000;
  localparam logic [PasscodeW-1:0] CodeOne     = 48'h0000_0000_0001;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  passcode_scoreboard  sb = new();
  bit                  steady;
  int unsigned         idle_cycles;
  logic [PasscodeW-1:0] pool [PoolSize];

  passcode_table_match_store u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always #2 clk = ~clk;

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [PasscodeW-1:0] rand_code();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PasscodeW-1:0];
  endfunction

  // send one request, starting and ending at a falling edge
  task automatic send_request(logic [ActionW-1:0] action, logic [PasscodeW-1:0] passcode,
                              logic [SlotIndexW-1:0] slot_index);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, slot_index, passcode, action};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(action, passcode, slot_index);
    @(negedge clk);
  endtask

  // result side: random stalls, check at each accepted result
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[2:0], m_axis_tdata[6:3]);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    int unsigned add_w;
    int unsigned r;
    int unsigned k;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    idle_cycles   = 0;
    foreach (pool[i]) pool[i] = rand_code();
    pool[0] = CodeMax;
    pool[1] = CodeOne;
    pool[2] = CodeMsb;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, misses, and the zero-code and duplicate rejections
    send_request(ACT_LOOKUP, '0, 4'd0);          // zero code never found
    send_request(ACT_LOOKUP, CodeMax, 4'd15);    // empty table miss
    send_request(ACT_ADD, '0, 4'd0);             // zero code rejected
    send_request(ACT_ADD, CodeMax, 4'd0);
    send_request(ACT_ADD, CodeOne, 4'd15);
    send_request(ACT_ADD, CodeMax, 4'd0);        // duplicate
    send_request(ACT_LOOKUP, CodeMax, 4'd0);
    send_request(ACT_LOOKUP, CodeOne, 4'd0);
    send_request(ACT_LOOKUP, '0, 4'd0);          // zero code with empty slots present
    send_request(ACT_DELETE, CodeMax, 4'd0);
    send_request(ACT_LOOKUP, CodeMax, 4'd0);
    send_request(ACT_ADD, CodeMsb, 4'd0);        // refills lowest empty slot
    send_request(ActUnused, CodeMsb, 4'd15);     // unused action
    send_request(ACT_DELETE, '0, 4'd15);         // clear an empty slot
    send_request(ACT_DELETE, CodeMax, 4'd15);
    send_request(ACT_LOOKUP, CodeMsb, 4'd5);

    // random: add-heavy and delete-heavy phases over a small code pool
    add_w = 55;
    for (int n = 0; n < RandomReqs; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n % 100 == 0) begin
        add_w = ($urandom_range(0, 1) != 0) ? 55 : 25;
        repeat (4) pool[$urandom_range(3, PoolSize - 1)] = rand_code();
      end
      r = $urandom_range(0, 99);
      k = $urandom_range(0, PoolSize - 1);
      if (r < add_w) begin
        send_request(ACT_ADD, pool[k], 4'($urandom_range(0, 15)));
      end else if (r < add_w + 25) begin
        send_request(ACT_LOOKUP, pool[k], 4'($urandom_range(0, 15)));
      end else if (r < 95) begin
        send_request(ACT_DELETE, rand_code(), 4'($urandom_range(0, 15)));
      end else begin
        // noise: zero codes, unused action, unknown codes
        case ($urandom_range(0, 3))
          0: send_request(ACT_LOOKUP, '0, 4'($urandom_range(0, 15)));
          1: send_request(ACT_ADD, '0, 4'($urandom_range(0, 15)));
          2: send_request(ActUnused, rand_code(), 4'($urandom_range(0, 15)));
          default: send_request(ACT_LOOKUP, rand_code(), 4'($urandom_range(0, 15)));
        endcase
      end
    end
    s_axis_tvalid = 1'b0;
    steady        = 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests: %0d done or found, %0d misses, %0d zero-code rejects",
             sb.requests, sb.status_hits[ST_OK], sb.status_hits[ST_NOT_FOUND],
             sb.status_hits[ST_ZERO]);
    $display("  %0d duplicate adds and %0d adds into a full table, %0d mismatches",
             sb.status_hits[ST_DUPLICATE], sb.status_hits[ST_FULL], sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ptms_pkg.sv
hdl/ptms_dp.sv
hdl/ptms_ctrl.sv
hdl/passcode_table_match_store.sv
bench/ptms_scoreboard_pkg.sv
bench/tb.sv
